// ===== design/bacl_pkg.sv =====
// ----------------------------------------------------------------------------
// bacl_pkg
// Shared types and constants for the binary arithmetic coder length meter.
// ----------------------------------------------------------------------------
package bacl_pkg;

  // Interval boundaries
  localparam logic [31:0] HalfPoint    = 32'h8000_0000;
  localparam logic [31:0] QuarterOne   = 32'h4000_0000;
  localparam logic [31:0] QuarterThree = 32'hc000_0000;
  localparam logic [31:0] IntervalTop  = 32'hffff_ffff;

  // Counter limits
  localparam logic [47:0] EmitMax = 48'hffff_ffff_ffff;
  localparam logic [31:0] PendMax = 32'hffff_ffff;

  // Renormalisation steps allowed per item
  localparam logic [6:0] RenormLimit = 7'd64;

  // Item kinds
  localparam logic KindEncode = 1'b0;
  localparam logic KindFinish = 1'b1;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULT,
    ST_CUT,
    ST_RENORM,
    ST_FINISH,
    ST_DONE
  } ctrl_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load_item;  // capture the accepted input beat
    logic do_mult;    // register span times complement probability
    logic do_cut;     // apply the clamped cut to the interval
    logic do_step;    // one renormalisation step
    logic do_finish;  // close the code: pending plus final emit
    logic load_out;   // fill the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic renorm_stop;  // no further renormalisation step applies
  } status_t;

endpackage

// ===== design/bacl_in_if.sv =====
// ----------------------------------------------------------------------------
// bacl_in_if
// Input channel: one beat is an encode or finish item.
// ----------------------------------------------------------------------------
interface bacl_in_if #(
  parameter int PROB_BITS = 12
);
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic                 bit_value;
  logic [PROB_BITS-1:0] prob_one;

  modport source (output valid, output kind, output bit_value, output prob_one, input ready);
  modport sink   (input valid, input kind, input bit_value, input prob_one, output ready);
endinterface

// ===== design/bacl_out_if.sv =====
// ----------------------------------------------------------------------------
// bacl_out_if
// Output channel: one beat carries the counts after one item.
// ----------------------------------------------------------------------------
interface bacl_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] bits_emitted;
  logic [31:0] bits_pending;
  logic [45:0] total_bytes;
  logic        finished;

  modport source (output valid, output bits_emitted, output bits_pending,
                  output total_bytes, output finished, input ready);
  modport sink   (input valid, input bits_emitted, input bits_pending,
                  input total_bytes, input finished, output ready);
endinterface

// ===== design/bacl_ctrl.sv =====
// ----------------------------------------------------------------------------
// bacl_ctrl
// Sequencer: walks encode items through multiply, cut, renormalisation and
// hand-off, finish items through final emit and hand-off; owns both handshakes.
// ----------------------------------------------------------------------------
module bacl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_kind_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  bacl_pkg::status_t status_i,
  output bacl_pkg::cmd_t    cmd_o
);

  bacl_pkg::ctrl_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_free;

  // State and output-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bacl_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output register may be refilled when empty or drained this cycle
  assign out_free = !out_valid_q || out_ready_i;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      bacl_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = (in_kind_i == bacl_pkg::KindFinish) ? bacl_pkg::ST_FINISH
                                                        : bacl_pkg::ST_MULT;
        end
      end
      bacl_pkg::ST_MULT: begin
        cmd_o.do_mult = 1'b1;
        state_d       = bacl_pkg::ST_CUT;
      end
      bacl_pkg::ST_CUT: begin
        cmd_o.do_cut = 1'b1;
        state_d      = bacl_pkg::ST_RENORM;
      end
      bacl_pkg::ST_RENORM: begin
        if (status_i.renorm_stop) begin
          state_d = bacl_pkg::ST_DONE;
        end else begin
          cmd_o.do_step = 1'b1;
        end
      end
      bacl_pkg::ST_FINISH: begin
        cmd_o.do_finish = 1'b1;
        state_d         = bacl_pkg::ST_DONE;
      end
      bacl_pkg::ST_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = bacl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bacl_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== design/bacl_datapath.sv =====
// ----------------------------------------------------------------------------
// bacl_datapath
// Interval, pending and emitted-bit registers, the cut multiplier, the
// one-step renormaliser and the output register.
// ----------------------------------------------------------------------------
module bacl_datapath #(
  parameter int PROB_BITS = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bacl_pkg::cmd_t       cmd_i,
  output bacl_pkg::status_t    status_o,
  input  logic                 kind_i,
  input  logic                 bit_value_i,
  input  logic [PROB_BITS-1:0] prob_one_i,
  output logic [47:0]          bits_emitted_o,
  output logic [31:0]          bits_pending_o,
  output logic [45:0]          total_bytes_o,
  output logic                 finished_o
);

  localparam int ProdW = 33 + PROB_BITS;
  localparam logic [PROB_BITS:0] ProbTotal = (PROB_BITS+1)'(1) << PROB_BITS;

  // Emitted count plus one bit plus the pending run, saturating
  function automatic logic [47:0] emit_add(input logic [47:0] e, input logic [31:0] p);
    logic [48:0] sum;
    sum = {1'b0, e} + {17'b0, p} + 49'd1;
    return sum[48] ? bacl_pkg::EmitMax : sum[47:0];
  endfunction

  // Pending count plus one, saturating
  function automatic logic [31:0] pend_inc(input logic [31:0] p);
    return (p == bacl_pkg::PendMax) ? p : p + 32'd1;
  endfunction

  logic [31:0]          low_q, low_d;
  logic [31:0]          high_q, high_d;
  logic [31:0]          pend_q, pend_d;
  logic [47:0]          emit_q, emit_d;
  logic [6:0]           step_q, step_d;
  logic                 kind_q;
  logic                 bit_q;
  logic [PROB_BITS-1:0] comp_q;     // (1 << PROB_BITS) - clamped probability
  logic [ProdW-1:0]     prod_q;

  logic [PROB_BITS-1:0] prob_clamped;
  logic [PROB_BITS:0]   comp_wide;
  logic [32:0]          span;
  logic [31:0]          cut_raw, cut;
  logic                 step_low_half, step_high_half, step_mid;
  logic [31:0]          step_low, step_high;
  logic [48:0]          bytes_sum;

  // Complement of the clamped probability
  assign prob_clamped = (prob_one_i == '0) ? PROB_BITS'(1) : prob_one_i;
  assign comp_wide    = ProbTotal - {1'b0, prob_clamped};

  // Interval width
  assign span = {1'b0, high_q} - {1'b0, low_q} + 33'd1;

  // Cut point with the degenerate cases pulled back inside the interval
  always_comb begin
    cut_raw = low_q + prod_q[PROB_BITS+31:PROB_BITS];
    cut     = cut_raw;
    if (cut <= low_q) begin
      cut = low_q + 32'd1;
    end
    if (cut > high_q) begin
      cut = high_q;
    end
  end

  // Renormalisation step decode
  assign step_high_half = !high_q[31];
  assign step_low_half  = low_q[31];
  assign step_mid       = (low_q[31:30] == 2'b01) && (high_q[31:30] == 2'b10);

  always_comb begin
    step_low  = low_q;
    step_high = high_q;
    if (!step_high_half && step_low_half) begin
      step_low  = low_q - bacl_pkg::HalfPoint;
      step_high = high_q - bacl_pkg::HalfPoint;
    end else if (!step_high_half && step_mid) begin
      step_low  = low_q - bacl_pkg::QuarterOne;
      step_high = high_q - bacl_pkg::QuarterOne;
    end
  end

  assign status_o.renorm_stop = (step_q == bacl_pkg::RenormLimit) ||
                                !(step_high_half || step_low_half || step_mid);

  // Coder state update
  always_comb begin
    low_d  = low_q;
    high_d = high_q;
    pend_d = pend_q;
    emit_d = emit_q;
    step_d = step_q;
    if (cmd_i.do_cut) begin
      step_d = '0;
      if (bit_q) begin
        low_d = cut;
      end else begin
        high_d = cut - 32'd1;
      end
    end
    if (cmd_i.do_step) begin
      step_d = step_q + 7'd1;
      low_d  = {step_low[30:0], 1'b0};
      high_d = {step_high[30:0], 1'b1};
      if (step_high_half || step_low_half) begin
        emit_d = emit_add(emit_q, pend_q);
        pend_d = '0;
      end else begin
        pend_d = pend_inc(pend_q);
      end
    end
    if (cmd_i.do_finish) begin
      emit_d = emit_add(emit_q, pend_inc(pend_q));
      pend_d = '0;
    end
    // Finish result handed off: coder back to its reset state
    if (cmd_i.load_out && kind_q) begin
      low_d  = '0;
      high_d = bacl_pkg::IntervalTop;
      pend_d = '0;
      emit_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= '0;
      high_q <= bacl_pkg::IntervalTop;
      pend_q <= '0;
      emit_q <= '0;
      step_q <= '0;
    end else begin
      low_q  <= low_d;
      high_q <= high_d;
      pend_q <= pend_d;
      emit_q <= emit_d;
      step_q <= step_d;
    end
  end

  // Item capture and product register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      kind_q <= kind_i;
      bit_q  <= bit_value_i;
      comp_q <= comp_wide[PROB_BITS-1:0];
    end
    if (cmd_i.do_mult) begin
      prod_q <= ProdW'(span) * ProdW'(comp_q);
    end
  end

  // Byte count, rounded up
  assign bytes_sum = {1'b0, emit_q} + 49'd7;

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      bits_emitted_o <= emit_q;
      bits_pending_o <= pend_q;
      total_bytes_o  <= kind_q ? bytes_sum[48:3] : '0;
      finished_o     <= kind_q;
    end
  end

endmodule

// ===== design/binary_arith_coder_length_meter.sv =====
// Sequence: an encode item passes through multiply, cut, renormalisation (one
//   interval shift per cycle) and hand-off; a finish, final emit and hand-off.
// Flow: one item at a time, with hand-off waiting for a free output register; the
//   next item is taken while the previous result waits in the output register.
// Reset: rst_ni asynchronous, active low; interval to full range, counts to 0.
// ----------------------------------------------------------------------------
// binary_arith_coder_length_meter
// Binary arithmetic coder that counts coded bits and reports the byte length.
// ----------------------------------------------------------------------------
module binary_arith_coder_length_meter #(
  parameter int PROB_BITS = 12
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  bacl_in_if.sink    in_i,
  bacl_out_if.source out_o
);

  bacl_pkg::cmd_t    cmd;
  bacl_pkg::status_t status;

  // Sequencer
  bacl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_kind_i   (in_i.kind),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Coder datapath
  bacl_datapath #(
    .PROB_BITS (PROB_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .kind_i         (in_i.kind),
    .bit_value_i    (in_i.bit_value),
    .prob_one_i     (in_i.prob_one),
    .bits_emitted_o (out_o.bits_emitted),
    .bits_pending_o (out_o.bits_pending),
    .total_bytes_o  (out_o.total_bytes),
    .finished_o     (out_o.finished)
  );

`ifndef NO_ASSERTIONS
  // Busy right after taking a beat
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input ready straight after an accepted beat");

  // Finish result has flushed pending bits and emitted at least one bit
  a_finish_flushed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.finished) |-> (out_o.bits_pending == '0 &&
                                         out_o.bits_emitted != '0))
    else $error("finish beat with pending bits or nothing emitted");

  // Byte count only on finish beats
  a_bytes_on_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.finished) |-> (out_o.total_bytes == '0))
    else $error("byte count on an encode beat");
`endif

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for binary_arith_coder_length_meter. A driver sends encode and
// finish beats taken from a queue. A monitor keeps its own copy of the coder
// interval and counters and works out the counts each beat should give. It
// then checks every output beat against the oldest of those, field by field.
// Directed beats cover the probability extremes, a rare symbol that needs a
// long renormalisation, underflow bits carried into a finish, and a finish on
// an empty code. Random coded sequences follow, run under four idling phases.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          ProbBits   = 12;
  localparam logic [63:0] ProbTotal  = 64'd1 << ProbBits;
  localparam int          CycleLimit = 600000;
  localparam int          DrainCycles = 80;
  localparam int          PhaseItems = 325;

  typedef struct packed {
    logic                kind;
    logic                bit_value;
    logic [ProbBits-1:0] prob_one;
  } coder_item_t;

  typedef struct packed {
    logic [47:0] bits_emitted;
    logic [31:0] bits_pending;
    logic [45:0] total_bytes;
    logic        finished;
  } length_count_t;

  logic clk_i;
  logic rst_ni;

  bacl_in_if #(.PROB_BITS(ProbBits)) in_if ();
  bacl_out_if out_if ();

  binary_arith_coder_length_meter #(
    .PROB_BITS(ProbBits)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Stimulus and expectation stores
  coder_item_t   item_q[$];
  length_count_t count_q[$];
  int unsigned   items_queued;
  int unsigned   items_taken;
  int unsigned   results_seen;
  int unsigned   errors;
  int unsigned   cycles;
  int unsigned   send_idle_pct;
  int unsigned   recv_stall_pct;
  logic          in_taken;

  // Predicted coder state
  logic [31:0] iv_low;
  logic [31:0] iv_high;
  logic [31:0] pend_bits;
  logic [47:0] emit_bits;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Known values on every input from time zero
  initial begin
    in_if.valid     = 1'b0;
    in_if.kind      = bacl_pkg::KindEncode;
    in_if.bit_value = 1'b0;
    in_if.prob_one  = '0;
    out_if.ready    = 1'b0;
    in_taken        = 1'b0;
  end

  // Watchdog
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  function automatic void coder_clear();
    iv_low    = 32'h0;
    iv_high   = bacl_pkg::IntervalTop;
    pend_bits = 32'h0;
    emit_bits = 48'h0;
  endfunction

  // One emitted bit releases all pending bits
  function automatic void tally_emit();
    logic [63:0] add;
    add = 64'd1 + {32'h0, pend_bits};
    if ({16'h0, emit_bits} > {16'h0, bacl_pkg::EmitMax} - add) emit_bits = bacl_pkg::EmitMax;
    else emit_bits = emit_bits + add[47:0];
    pend_bits = 32'h0;
  endfunction

  function automatic void tally_pending();
    if (pend_bits != bacl_pkg::PendMax) pend_bits = pend_bits + 32'd1;
  endfunction

  function automatic void coder_encode(input logic bit_value, input logic [ProbBits-1:0] prob);
    logic [63:0] p;
    logic [63:0] span;
    logic [63:0] part;
    logic [31:0] cut;
    logic        settled;
    int          step;
    p = {{(64-ProbBits){1'b0}}, prob};
    if (p < 64'd1) p = 64'd1;
    if (p > ProbTotal - 64'd1) p = ProbTotal - 64'd1;
    span = {32'h0, iv_high} - {32'h0, iv_low} + 64'd1;
    part = (span * (ProbTotal - p)) >> ProbBits;
    cut  = iv_low + part[31:0];
    // guard the cut against a collapsed interval
    if (cut <= iv_low) cut = iv_low + 32'd1;
    if (cut > iv_high) cut = iv_high;
    if (bit_value) iv_low = cut;
    else iv_high = cut - 32'd1;
    // renormalise with half and quarter steps
    settled = 1'b0;
    for (step = 0; step < int'(bacl_pkg::RenormLimit) && !settled; step++) begin
      if (iv_high < bacl_pkg::HalfPoint) begin
        tally_emit();
      end else if (iv_low >= bacl_pkg::HalfPoint) begin
        tally_emit();
        iv_low  = iv_low - bacl_pkg::HalfPoint;
        iv_high = iv_high - bacl_pkg::HalfPoint;
      end else if (iv_low >= bacl_pkg::QuarterOne && iv_high < bacl_pkg::QuarterThree) begin
        tally_pending();
        iv_low  = iv_low - bacl_pkg::QuarterOne;
        iv_high = iv_high - bacl_pkg::QuarterOne;
      end else begin
        settled = 1'b1;
      end
      if (!settled) begin
        iv_low  = iv_low << 1;
        iv_high = (iv_high << 1) | 32'd1;
      end
    end
  endfunction

  // Expected counts for one accepted beat
  function automatic length_count_t predict_counts(input coder_item_t it);
    length_count_t r;
    logic [63:0]   rounded;
    r = '0;
    if (it.kind == bacl_pkg::KindEncode) begin
      coder_encode(it.bit_value, it.prob_one);
      r.bits_emitted = emit_bits;
      r.bits_pending = pend_bits;
    end else begin
      tally_pending();
      tally_emit();
      rounded        = ({16'h0, emit_bits} + 64'd7) >> 3;
      r.bits_emitted = emit_bits;
      r.bits_pending = pend_bits;
      r.total_bytes  = rounded[45:0];
      r.finished     = 1'b1;
      coder_clear();
    end
    return r;
  endfunction

  // Input driver: a new beat or a gap after each accepted beat
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      if (item_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_if.valid     <= 1'b1;
        in_if.kind      <= item_q[0].kind;
        in_if.bit_value <= item_q[0].bit_value;
        in_if.prob_one  <= item_q[0].prob_one;
        void'(item_q.pop_front());
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Output back-pressure
  always @(negedge clk_i) begin
    if (!rst_ni) out_if.ready <= 1'b0;
    else out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Monitor: predict on input beats, check output beats
  always @(posedge clk_i) begin
    length_count_t want;
    length_count_t got;
    if (rst_ni) begin
      in_taken <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        count_q.insert(count_q.size(),
                       predict_counts({in_if.kind, in_if.bit_value, in_if.prob_one}));
        items_taken++;
      end
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        got = {out_if.bits_emitted, out_if.bits_pending, out_if.total_bytes, out_if.finished};
        if (count_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat: emitted %0d pending %0d",
                                     got.bits_emitted, got.bits_pending);
        end else begin
          want = count_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display({"result %0d mismatch: emitted %0d/%0d pending %0d/%0d ",
                        "bytes %0d/%0d finished %0b/%0b (expected/actual)"},
                       results_seen, want.bits_emitted, got.bits_emitted,
                       want.bits_pending, got.bits_pending, want.total_bytes,
                       got.total_bytes, want.finished, got.finished);
          end
        end
      end
    end
  end

  task automatic queue_item(input logic kind, input logic bit_value,
                            input logic [ProbBits-1:0] prob);
    coder_item_t it;
    it.kind      = kind;
    it.bit_value = bit_value;
    it.prob_one  = prob;
    item_q.insert(item_q.size(), it);
    items_queued++;
  endtask

  // Probability of one: mostly spread, some at or near the extremes
  function automatic logic [ProbBits-1:0] pick_prob();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return ProbBits'($urandom_range(0, 15));
      3: return ProbBits'(4095 - $urandom_range(0, 15));
      4: return ProbBits'(2048);
      default: return ProbBits'($urandom_range(0, 4095));
    endcase
  endfunction

  // A coded sequence: encodes with random content, mostly closed by a finish
  task automatic queue_sequence();
    int unsigned          len;
    int unsigned          n;
    logic [ProbBits-1:0]  p;
    logic                 b;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(0, 14);
    for (n = 0; n < len; n++) begin
      p = pick_prob();
      // bits mostly follow the probability, so intervals stay wide
      if ($urandom_range(0, 3) != 0) b = ($urandom_range(0, 4095) < p);
      else b = 1'($urandom_range(0, 1));
      queue_item(bacl_pkg::KindEncode, b, p);
    end
    if ($urandom_range(0, 9) != 0)
      queue_item(bacl_pkg::KindFinish, 1'($urandom_range(0, 1)),
                 ProbBits'($urandom_range(0, 4095)));
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    int unsigned target;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    target = items_queued + PhaseItems;
    while (items_queued < target) queue_sequence();
    wait (items_taken == items_queued && results_seen == items_taken);
  endtask

  // Main sequence
  initial begin
    int n;
    items_queued   = 0;
    items_taken    = 0;
    results_seen   = 0;
    errors         = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    coder_clear();
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: finish on an empty code
    queue_item(bacl_pkg::KindFinish, 1'b0, '0);
    // probability extremes, both symbols; zero acts as one
    queue_item(bacl_pkg::KindEncode, 1'b0, '0);
    queue_item(bacl_pkg::KindEncode, 1'b1, '0);
    queue_item(bacl_pkg::KindEncode, 1'b0, '1);
    queue_item(bacl_pkg::KindEncode, 1'b1, '1);
    queue_item(bacl_pkg::KindEncode, 1'b1, ProbBits'(1));
    queue_item(bacl_pkg::KindEncode, 1'b0, ProbBits'(4094));
    queue_item(bacl_pkg::KindEncode, 1'b1, ProbBits'(12'haaa));
    queue_item(bacl_pkg::KindEncode, 1'b0, ProbBits'(12'h555));
    queue_item(bacl_pkg::KindFinish, 1'b1, '1);
    // straddle the midpoint so an underflow bit waits for the finish
    queue_item(bacl_pkg::KindEncode, 1'b1, ProbBits'(3072));
    queue_item(bacl_pkg::KindEncode, 1'b0, ProbBits'(2048));
    queue_item(bacl_pkg::KindFinish, 1'b0, ProbBits'(2048));
    // rare symbols: long renormalisation
    for (n = 0; n < 4; n++) queue_item(bacl_pkg::KindEncode, 1'b1, ProbBits'(1));
    queue_item(bacl_pkg::KindEncode, 1'b0, '1);
    queue_item(bacl_pkg::KindEncode, 1'b0, ProbBits'(2048));
    queue_item(bacl_pkg::KindFinish, 1'b1, ProbBits'(1));
    queue_item(bacl_pkg::KindFinish, 1'b0, '0);
    wait (items_taken == items_queued && results_seen == items_taken);

    // random sequences under each idling pattern
    run_phase(0, 0);
    run_phase(85, 0);
    run_phase(0, 85);
    run_phase(23, 23);

    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && count_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/bacl_pkg.sv
design/bacl_in_if.sv
design/bacl_out_if.sv
design/bacl_ctrl.sv
design/bacl_datapath.sv
design/binary_arith_coder_length_meter.sv
dv/tb.sv
